// File: rtl/core/nrtm_pkg.sv
// Shared constants, codes and types of the nested range trace matcher.
`default_nettype none

package nrtm_pkg;

   localparam int RANGE_TYPES = 8;
   localparam int STACK_DEPTH = 16;
   localparam int EVENT_KINDS = 16;
   localparam int TIME_BITS   = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam int GAP_W      = 16;
   localparam logic [GAP_W-1:0] GAP_DEFAULT = 16'd150;

   localparam int ACTION_W   = 2;
   localparam int EVENT_W    = 4;
   localparam int RANGE_W    = 4;
   localparam int KIND_W     = 3;
   localparam int DUR_W      = TIME_BITS + 1;
   localparam int TYPE_W     = (RANGE_TYPES > 1) ? $clog2(RANGE_TYPES) : 1;
   localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
   localparam int MEM_DEPTH  = RANGE_TYPES * STACK_DEPTH;
   localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [EVENT_W-1:0] EV_TRACE_START = 4'd0;
   localparam logic [EVENT_W-1:0] EV_TRACE_END   = 4'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_POINT       = 2'd0,
      ACT_COMPLETE    = 2'd1,
      ACT_RANGE_START = 2'd2,
      ACT_RANGE_END   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      RK_GAP      = 3'd0,
      RK_STARTED  = 3'd1,
      RK_FINISHED = 3'd2,
      RK_EVENT    = 3'd3,
      RK_COMPLETE = 3'd4,
      RK_RANGE    = 3'd5,
      RK_OVERFLOW = 3'd6
   } result_kind_type;

   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_TRACE_START = 3'd1,
      OP_TRACE_END   = 3'd2,
      OP_EVENT       = 3'd3,
      OP_COMPLETE    = 3'd4,
      OP_PUSH        = 3'd5,
      OP_POP         = 3'd6
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [TIME_BITS-1:0] stamp;
      logic [EVENT_W-1:0]   event_kind;
      logic [RANGE_W-1:0]   range_type;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/nrtm_front.sv
// Front end: accepts trace requests and classifies them into commands.
`default_nettype none

module nrtm_front (
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [nrtm_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [nrtm_pkg::TIME_BITS-1:0]     req_timestamp,
   input  wire logic [nrtm_pkg::EVENT_W-1:0]       req_event_kind,
   input  wire logic [nrtm_pkg::RANGE_W-1:0]       req_range_type,
   input  wire logic                               q_full,
   output logic                                    push_valid,
   output nrtm_pkg::cmd_type                       push_cmd
);

   nrtm_pkg::op_type op;
   logic             type_ok;

   assign type_ok = (req_range_type < nrtm_pkg::RANGE_TYPES);

   always_comb begin
      op = nrtm_pkg::OP_NONE;
      unique case (nrtm_pkg::action_type'(req_action))
         nrtm_pkg::ACT_POINT: begin
            if (req_event_kind == nrtm_pkg::EV_TRACE_END) begin
               op = nrtm_pkg::OP_TRACE_END;
            end else if (req_event_kind == nrtm_pkg::EV_TRACE_START) begin
               op = nrtm_pkg::OP_TRACE_START;
            end else if (req_event_kind < nrtm_pkg::EVENT_KINDS) begin
               op = nrtm_pkg::OP_EVENT;
            end
         end
         nrtm_pkg::ACT_COMPLETE: begin
            op = nrtm_pkg::OP_COMPLETE;
         end
         nrtm_pkg::ACT_RANGE_START: begin
            if (type_ok) begin
               op = nrtm_pkg::OP_PUSH;
            end
         end
         nrtm_pkg::ACT_RANGE_END: begin
            if (type_ok) begin
               op = nrtm_pkg::OP_POP;
            end
         end
         default: begin
            op = nrtm_pkg::OP_NONE;
         end
      endcase
   end

   assign req_stall           = q_full;
   assign push_valid          = req_valid && !q_full;
   assign push_cmd.op         = op;
   assign push_cmd.stamp      = req_timestamp;
   assign push_cmd.event_kind = req_event_kind;
   assign push_cmd.range_type = req_range_type;

endmodule

`default_nettype wire

// File: rtl/core/nrtm_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module nrtm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire nrtm_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output nrtm_pkg::cmd_type      head
);

   localparam logic [nrtm_pkg::QPTR_W-1:0] LAST_PTR =
      nrtm_pkg::QPTR_W'(nrtm_pkg::QUEUE_DEPTH - 1);
   localparam logic [nrtm_pkg::QCNT_W-1:0] FULL_CNT =
      nrtm_pkg::QCNT_W'(nrtm_pkg::QUEUE_DEPTH);

   nrtm_pkg::cmd_type              entry_ff [nrtm_pkg::QUEUE_DEPTH];
   logic [nrtm_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [nrtm_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [nrtm_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/nrtm_back.sv
// Back end: trace state, range stacks, gap check and result output register.
`default_nettype none

module nrtm_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [nrtm_pkg::GAP_W-1:0]          csr_wr_data,
   input  wire logic                                q_valid,
   input  wire nrtm_pkg::cmd_type                   q_head,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [nrtm_pkg::KIND_W-1:0]              rsp_result_kind,
   output logic [nrtm_pkg::TIME_BITS-1:0]           rsp_result_time,
   output logic [nrtm_pkg::EVENT_W-1:0]             rsp_result_event,
   output logic [nrtm_pkg::RANGE_W-1:0]             rsp_result_range_type,
   output logic signed [nrtm_pkg::DUR_W-1:0]        rsp_range_duration,
   output logic                                     rsp_last_result
);

   localparam int TB = nrtm_pkg::TIME_BITS;
   localparam int DW = nrtm_pkg::DUR_W;
   localparam int AW = nrtm_pkg::ADDR_W;
   localparam int PW = nrtm_pkg::DEPTH_W;
   localparam int YW = nrtm_pkg::TYPE_W;
   localparam int RT = nrtm_pkg::RANGE_TYPES;
   localparam logic [PW-1:0] DEPTH_FULL = PW'(nrtm_pkg::STACK_DEPTH);
   localparam logic [AW-1:0] ROW_SIZE   = AW'(nrtm_pkg::STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_EVAL = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [nrtm_pkg::GAP_W-1:0]    gap_ff;
   logic [TB-1:0]                 latest_ff, latest_in;
   logic [RT-1:0]                 open_ff, open_in;
   logic [PW-1:0]                 depth_ff [RT];
   logic                          depth_we;
   logic [PW-1:0]                 depth_wdata;
   logic [TB-1:0]                 stack_mem [nrtm_pkg::MEM_DEPTH];
   logic                          mem_we;
   logic [AW-1:0]                 mem_wr_addr;
   logic [AW-1:0]                 mem_rd_addr;
   logic [TB-1:0]                 mem_rd_ff;

   nrtm_pkg::cmd_type             cmd_ff;
   logic [PW-1:0]                 depth_rd_ff;
   logic [PW-1:0]                 head_depth;
   logic [YW-1:0]                 head_idx;
   logic [YW-1:0]                 cmd_idx;

   logic                          gap_pend_ff, gap_pend_in;
   logic                          main_pend_ff, main_pend_in;
   nrtm_pkg::result_kind_type     main_kind_ff, main_kind_in;
   logic [TB-1:0]                 main_time_ff, main_time_in;
   logic [nrtm_pkg::EVENT_W-1:0]  main_event_ff, main_event_in;
   logic [nrtm_pkg::RANGE_W-1:0]  main_range_ff, main_range_in;
   logic [DW-1:0]                 main_dur_ff, main_dur_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;
   nrtm_pkg::result_kind_type     rsp_kind_ff, rsp_kind_in;
   logic [TB-1:0]                 rsp_time_ff, rsp_time_in;
   logic [nrtm_pkg::EVENT_W-1:0]  rsp_event_ff, rsp_event_in;
   logic [nrtm_pkg::RANGE_W-1:0]  rsp_range_ff, rsp_range_in;
   logic [DW-1:0]                 rsp_dur_ff, rsp_dur_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          gap_hit;
   logic                          later;
   logic                          done;

   assign head_idx    = q_head.range_type[YW-1:0];
   assign cmd_idx     = cmd_ff.range_type[YW-1:0];
   assign head_depth  = depth_ff[head_idx];
   assign mem_rd_addr = AW'(head_idx) * ROW_SIZE + AW'(head_depth - 1'b1);
   assign mem_wr_addr = AW'(cmd_idx) * ROW_SIZE + AW'(depth_rd_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign gap_hit     = ({1'b0, cmd_ff.stamp} > ({1'b0, latest_ff} + DW'(gap_ff)))
                        && (open_ff == '0);
   assign later       = cmd_ff.stamp > latest_ff;

   always_comb begin
      state_in      = state_ff;
      q_pop         = 1'b0;
      done          = 1'b0;
      latest_in     = latest_ff;
      open_in       = open_ff;
      depth_we      = 1'b0;
      depth_wdata   = depth_rd_ff;
      mem_we        = 1'b0;
      gap_pend_in   = gap_pend_ff;
      main_pend_in  = main_pend_ff;
      main_kind_in  = main_kind_ff;
      main_time_in  = main_time_ff;
      main_event_in = main_event_ff;
      main_range_in = main_range_ff;
      main_dur_in   = main_dur_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_dur_in    = rsp_dur_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            gap_pend_in   = gap_hit;
            main_pend_in  = 1'b0;
            main_kind_in  = nrtm_pkg::RK_COMPLETE;
            main_time_in  = cmd_ff.stamp;
            main_event_in = '0;
            main_range_in = '0;
            main_dur_in   = '0;
            case (cmd_ff.op)
               nrtm_pkg::OP_TRACE_START: begin
                  main_pend_in = 1'b1;
                  main_kind_in = nrtm_pkg::RK_STARTED;
                  latest_in    = cmd_ff.stamp;
               end
               nrtm_pkg::OP_TRACE_END: begin
                  main_pend_in = 1'b1;
                  main_kind_in = nrtm_pkg::RK_FINISHED;
                  latest_in    = cmd_ff.stamp;
               end
               nrtm_pkg::OP_EVENT: begin
                  main_pend_in  = 1'b1;
                  main_kind_in  = nrtm_pkg::RK_EVENT;
                  main_event_in = cmd_ff.event_kind;
                  if (later) begin
                     latest_in = cmd_ff.stamp;
                  end
               end
               nrtm_pkg::OP_COMPLETE: begin
                  main_pend_in = 1'b1;
               end
               nrtm_pkg::OP_PUSH: begin
                  if (depth_rd_ff >= DEPTH_FULL) begin
                     main_pend_in  = 1'b1;
                     main_kind_in  = nrtm_pkg::RK_OVERFLOW;
                     main_range_in = cmd_ff.range_type;
                  end else begin
                     mem_we           = 1'b1;
                     depth_we         = 1'b1;
                     depth_wdata      = depth_rd_ff + 1'b1;
                     open_in[cmd_idx] = 1'b1;
                  end
               end
               nrtm_pkg::OP_POP: begin
                  if (depth_rd_ff != '0) begin
                     depth_we         = 1'b1;
                     depth_wdata      = depth_rd_ff - 1'b1;
                     open_in[cmd_idx] = 1'b0;
                     if (later) begin
                        latest_in = cmd_ff.stamp;
                     end
                     main_pend_in  = 1'b1;
                     main_kind_in  = nrtm_pkg::RK_RANGE;
                     main_time_in  = mem_rd_ff;
                     main_range_in = cmd_ff.range_type;
                     main_dur_in   = {1'b0, cmd_ff.stamp} - {1'b0, mem_rd_ff};
                  end
               end
               default: begin
                  main_pend_in = 1'b0;
               end
            endcase
            state_in = (gap_pend_in || main_pend_in) ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (gap_pend_ff) begin
                  rsp_kind_in  = nrtm_pkg::RK_GAP;
                  rsp_time_in  = cmd_ff.stamp;
                  rsp_event_in = '0;
                  rsp_range_in = '0;
                  rsp_dur_in   = '0;
                  rsp_last_in  = !main_pend_ff;
                  gap_pend_in  = 1'b0;
                  done         = !main_pend_ff;
               end else begin
                  rsp_kind_in  = main_kind_ff;
                  rsp_time_in  = main_time_ff;
                  rsp_event_in = main_event_ff;
                  rsp_range_in = main_range_ff;
                  rsp_dur_in   = main_dur_ff;
                  rsp_last_in  = 1'b1;
                  main_pend_in = 1'b0;
                  done         = 1'b1;
               end
               if (done) begin
                  q_pop    = q_valid;
                  state_in = q_valid ? ST_EVAL : ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         gap_ff       <= nrtm_pkg::GAP_DEFAULT;
         latest_ff    <= '0;
         open_ff      <= '0;
         gap_pend_ff  <= 1'b0;
         main_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RT; i++) begin
            depth_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         latest_ff    <= latest_in;
         open_ff      <= open_in;
         gap_pend_ff  <= gap_pend_in;
         main_pend_ff <= main_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
         if (depth_we) begin
            depth_ff[cmd_idx] <= depth_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      main_kind_ff  <= main_kind_in;
      main_time_ff  <= main_time_in;
      main_event_ff <= main_event_in;
      main_range_ff <= main_range_in;
      main_dur_ff   <= main_dur_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_dur_ff    <= rsp_dur_in;
      rsp_last_ff   <= rsp_last_in;
      if (q_pop) begin
         cmd_ff      <= q_head;
         depth_rd_ff <= head_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wr_addr] <= cmd_ff.stamp;
      end
      if (q_pop) begin
         mem_rd_ff <= stack_mem[mem_rd_addr];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_result_time       = rsp_time_ff;
   assign rsp_result_event      = rsp_event_ff;
   assign rsp_result_range_type = rsp_range_ff;
   assign rsp_range_duration    = $signed(rsp_dur_ff);
   assign rsp_last_result       = rsp_last_ff;

`ifndef SYNTHESIS
   a_first_of_two_has_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> main_pend_ff)
      else $error("non-final result without a pending second result");

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> depth_rd_ff <= DEPTH_FULL)
      else $error("stack depth beyond capacity");

   a_empty_type_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && cmd_ff.op == nrtm_pkg::OP_POP && depth_rd_ff == '0
      |-> !open_ff[cmd_idx])
      else $error("range type open with empty stack");

   a_no_pop_in_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> !q_pop)
      else $error("command dequeued while previous one evaluates");
`endif

endmodule

`default_nettype wire

// File: rtl/core/nested_range_trace_matcher.sv
// Top level of the nested range trace matcher.
//
// Usage: trace messages enter on the req_ channel (valid/stall); each accepted
// request produces zero, one or two results on the rsp_ channel, the last one
// flagged by rsp_last_result. A gap result, when reported, always comes first.
// csr_wr_en/csr_wr_data write the gap threshold (reset value 150); write it
// only while no request is in flight.
// Each request passes through the back end sequence of stack memory read
// (with the dequeue), evaluate and emit into the output register. The back
// end dequeues the next command only while it emits the last result of the
// current one, or from its idle load state after a request with no result.
// A two-entry command queue decouples the front end; req_stall rises when
// it is full. rsp_stall holds the output register and, once the back end
// waits on it, the queue fills and requests stall.
// Reset (synchronous, active high) clears the latest time, the open mask,
// all stack depths, the queue and the output valid; stack memory contents
// are not cleared, and no clearing pass is needed.
`default_nettype none

module nested_range_trace_matcher (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [nrtm_pkg::GAP_W-1:0]          csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [nrtm_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [nrtm_pkg::TIME_BITS-1:0]      req_timestamp,
   input  wire logic [nrtm_pkg::EVENT_W-1:0]        req_event_kind,
   input  wire logic [nrtm_pkg::RANGE_W-1:0]        req_range_type,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [nrtm_pkg::KIND_W-1:0]              rsp_result_kind,
   output logic [nrtm_pkg::TIME_BITS-1:0]           rsp_result_time,
   output logic [nrtm_pkg::EVENT_W-1:0]             rsp_result_event,
   output logic [nrtm_pkg::RANGE_W-1:0]             rsp_result_range_type,
   output logic signed [nrtm_pkg::DUR_W-1:0]        rsp_range_duration,
   output logic                                     rsp_last_result
);

   logic              q_full;
   logic              push_valid;
   nrtm_pkg::cmd_type push_cmd;
   logic              q_pop;
   logic              q_valid;
   nrtm_pkg::cmd_type q_head;

   nrtm_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_timestamp  (req_timestamp),
      .req_event_kind (req_event_kind),
      .req_range_type (req_range_type),
      .q_full         (q_full),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd)
   );

   nrtm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   nrtm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .q_valid               (q_valid),
      .q_head                (q_head),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_result_time       (rsp_result_time),
      .rsp_result_event      (rsp_result_event),
      .rsp_result_range_type (rsp_result_range_type),
      .rsp_range_duration    (rsp_range_duration),
      .rsp_last_result       (rsp_last_result)
   );

endmodule

`default_nettype wire
